@@ rtl/aes128_key_expansion_top_macros.svh @@
// Assertion macros for the AES-128 key expansion block.
// Used by aes128_key_expansion_top; no other dependencies.
`ifndef AES128_KEY_EXPANSION_TOP_MACROS_SVH
`define AES128_KEY_EXPANSION_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define AKX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key expansion check failed");
`define AKX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key expansion sequence check failed");
`else
`define AKX_ASSERT_SAME(label, clk, rst, ante, cons)
`define AKX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/aes_kx_pkg.sv @@
// Package for the AES-128 key expansion block: item types, S-box and round constants.
// No dependencies.
`timescale 1ns / 1ps

package aes_kx_pkg;

   localparam int unsigned NUM_ROUND_KEYS = 11;
   localparam logic [3:0]  FIRST_ROUND    = 4'd0;
   localparam logic [3:0]  LAST_ROUND     = 4'(NUM_ROUND_KEYS - 1);

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
   } aes_kx_req_type;

   typedef struct packed {
      logic [3:0]  round_index;
      logic [63:0] round_key_high;
      logic [63:0] round_key_low;
      logic        last;
   } aes_kx_rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // round constant used to build round key (rnd + 1) from round key rnd
   function automatic logic [7:0] rcon(input logic [3:0] rnd);
      logic [7:0] rc;
      case (rnd)
         4'd0:    rc = 8'h01;
         4'd1:    rc = 8'h02;
         4'd2:    rc = 8'h04;
         4'd3:    rc = 8'h08;
         4'd4:    rc = 8'h10;
         4'd5:    rc = 8'h20;
         4'd6:    rc = 8'h40;
         4'd7:    rc = 8'h80;
         4'd8:    rc = 8'h1b;
         4'd9:    rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

   function automatic logic [127:0] next_round_key(input logic [127:0] key,
                                                   input logic [3:0]   rnd);
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      logic [31:0] t;
      w0 = key[127:96];
      w1 = key[95:64];
      w2 = key[63:32];
      w3 = key[31:0];
      t  = sub_word({w3[23:0], w3[31:24]}) ^ {rcon(rnd), 24'h000000};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

@@ rtl/aes128_key_expansion_top.sv @@
// AES-128 key expansion, top level. Depends on aes_kx_pkg and
// aes128_key_expansion_top_macros.svh.
//
// req channel: one item is a 128-bit cipher key (key_high, key_low).
// rsp channel: eleven items per key, round 0 (the cipher key) to round 10,
// each with its round index; last is set on round 10.
// Order: an accepted key waits in the input register, then loads into the result
// register as round 0; each later round key follows once the previous one is taken.
// Throughput: the rsp channel carries one round key per cycle while rsp_stall
// is low. The next key is held in an input register while the current
// run drains and loads in the cycle that round 10 is taken, so runs follow
// with no gap. Each round key is built in one pass (four S-box lookups and
// an XOR chain) from the result register into itself.
// Stall: rsp_stall holds the result register; req_stall rises only while a
// key waits in the input register and the result register cannot take it.
// Reset: clears both valid flags; no item is pending afterwards.
`timescale 1ns / 1ps
`include "aes128_key_expansion_top_macros.svh"

module aes128_key_expansion_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  aes_kx_pkg::aes_kx_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output aes_kx_pkg::aes_kx_rsp_type rsp_data
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   aes_kx_pkg::aes_kx_req_type in_key_ff;
   aes_kx_pkg::aes_kx_req_type in_key_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   aes_kx_pkg::aes_kx_rsp_type out_ff;
   aes_kx_pkg::aes_kx_rsp_type out_in;

   logic         req_take;
   logic         out_free;
   logic         out_adv;
   logic         load;
   logic [3:0]   next_index;
   logic [127:0] derived_key;

   assign out_free    = !out_valid_ff || (!rsp_stall && out_ff.last);
   assign out_adv     = out_valid_ff && !rsp_stall && !out_ff.last;
   assign load        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_take    = req_valid && !req_stall;
   assign next_index  = out_ff.round_index + 4'd1;
   assign derived_key = aes_kx_pkg::next_round_key(
                           {out_ff.round_key_high, out_ff.round_key_low},
                           out_ff.round_index);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_key_in   = in_key_ff;
      if (load) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_key_in   = req_data;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_valid_in          = 1'b1;
         out_in.round_index    = aes_kx_pkg::FIRST_ROUND;
         out_in.round_key_high = in_key_ff.key_high;
         out_in.round_key_low  = in_key_ff.key_low;
         out_in.last           = 1'b0;
      end else if (out_adv) begin
         out_in.round_index    = next_index;
         out_in.round_key_high = derived_key[127:64];
         out_in.round_key_low  = derived_key[63:0];
         out_in.last           = (next_index == aes_kx_pkg::LAST_ROUND);
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_key_ff <= in_key_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `AKX_ASSERT_SAME(last_on_final_round, clock, reset, out_valid_ff,
      out_ff.last == (out_ff.round_index == aes_kx_pkg::LAST_ROUND))
   `AKX_ASSERT_NEXT(round_advances, clock, reset, out_adv,
      out_valid_ff && out_ff.round_index == $past(out_ff.round_index) + 4'd1)
   `AKX_ASSERT_SAME(round_in_range, clock, reset, out_valid_ff,
      out_ff.round_index <= aes_kx_pkg::LAST_ROUND)
   `AKX_ASSERT_SAME(stall_only_when_held, clock, reset, !in_valid_ff, !req_stall)

endmodule
